// ===== src/aem_pkg.sv =====
// shared types and register map for the annealing equilibrium monitor
package aem_pkg;

  // register index, taken from the word address of the config port
  typedef enum logic [1:0] {
    REG_AVERAGE_COST    = 2'd0,
    REG_BAND_HALFWIDTH  = 2'd1,
    REG_TOLERANCE_LIMIT = 2'd2,
    REG_TARGET_COUNT    = 2'd3
  } reg_idx_t;

  // one result item
  typedef struct packed {
    logic frozen;
    logic counts_cleared;
    logic equilibrium_reached;
  } aem_result_t;

endpackage

// ===== src/annealing_equilibrium_monitor.sv =====
// top level of the annealing equilibrium and frozen monitor
//
// each input transfer carries one annealing step (step cost and current cost, signed
// fixed point with 16 fraction bits) and yields exactly one result transfer with the
// equilibrium, counts-cleared and frozen flags. one step is taken every clock cycle
// unless a waiting result stalls it: an item is held in the input register, the
// statistics and band counters update in a single pass of compares and subtractions,
// and the flags land in the result register as the held item moves on, which waits
// while an earlier result is not taken. while a result waits, one more item can
// enter the input register; after that the input stalls until the result is taken.
// configuration registers sit on the apb-style port at byte address 4*i (8*i when
// costs are wider than 32 bits) and should be written only while no step is in flight.
module annealing_equilibrium_monitor #(
  parameter int COST_WIDTH  = 31,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // input stream
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  input  logic [((2 * COST_WIDTH + 7) / 8) * 8-1:0]  s_tdata,  // step_cost, current_cost, zero pad
  // result stream
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  output logic [7:0]                                 m_tdata,  // equilibrium_reached, counts_cleared, frozen, zero pad
  // configuration
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [((COST_WIDTH > 32) ? 5 : 4)-1:0]     paddr,
  input  logic [((COST_WIDTH > 32) ? 64 : 32)-1:0]   pwdata,
  output logic [((COST_WIDTH > 32) ? 64 : 32)-1:0]   prdata,
  output logic                                       pready
);

  localparam int IN_DATA_W = ((2 * COST_WIDTH + 7) / 8) * 8;
  localparam int PDATA_W   = (COST_WIDTH > 32) ? 64 : 32;
  localparam int PADDR_W   = (COST_WIDTH > 32) ? 5 : 4;

  logic signed [COST_WIDTH-1:0]  average_cost;
  logic [COST_WIDTH-1:0]         band_halfwidth;
  logic [COUNT_WIDTH-1:0]        tolerance_limit;
  logic [COUNT_WIDTH-1:0]        target_count;

  // input register
  logic                          in_full;
  logic signed [COST_WIDTH-1:0]  step_q;
  logic signed [COST_WIDTH-1:0]  cur_q;

  // result register
  aem_pkg::aem_result_t          result;
  aem_pkg::aem_result_t          result_q;
  logic                          advance;

  assign pready = 1'b1;

  aem_regs #(
    .COST_WIDTH  (COST_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH),
    .PDATA_W     (PDATA_W),
    .PADDR_W     (PADDR_W)
  ) u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .average_cost    (average_cost),
    .band_halfwidth  (band_halfwidth),
    .tolerance_limit (tolerance_limit),
    .target_count    (target_count)
  );

  // the held step moves on when the result register is empty or being drained
  assign advance  = in_full && (!m_tvalid || m_tready);
  assign s_tready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      step_q <= s_tdata[COST_WIDTH-1:0];
      cur_q  <= s_tdata[2*COST_WIDTH-1:COST_WIDTH];
    end
  end

  aem_core #(
    .COST_WIDTH  (COST_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .step_cost       (step_q),
    .current_cost    (cur_q),
    .average_cost    (average_cost),
    .band_halfwidth  (band_halfwidth),
    .tolerance_limit (tolerance_limit),
    .target_count    (target_count),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign m_tdata = {5'b0, result_q.frozen, result_q.counts_cleared,
                    result_q.equilibrium_reached};

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !advance)
    else $error("result register overwritten while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_full |-> s_tready)
    else $error("input not ready while input register empty");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("no result after a step moved on");
`endif

endmodule

// ===== src/aem_regs.sv =====
// configuration register file behind the apb-style port
module aem_regs #(
  parameter int COST_WIDTH  = 31,
  parameter int COUNT_WIDTH = 16,
  parameter int PDATA_W     = 32,
  parameter int PADDR_W     = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [PDATA_W-1:0]            pwdata,
  output logic [PDATA_W-1:0]            prdata,
  output logic signed [COST_WIDTH-1:0]  average_cost,
  output logic [COST_WIDTH-1:0]         band_halfwidth,
  output logic [COUNT_WIDTH-1:0]        tolerance_limit,
  output logic [COUNT_WIDTH-1:0]        target_count
);

  aem_pkg::reg_idx_t idx;
  logic              wr_en;

  // word address: drop the byte offset bits
  assign idx   = aem_pkg::reg_idx_t'(paddr[PADDR_W-1:PADDR_W-2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      average_cost    <= '0;
      band_halfwidth  <= '0;
      tolerance_limit <= '0;
      target_count    <= '0;
    end else if (wr_en) begin
      case (idx)
        aem_pkg::REG_AVERAGE_COST:    average_cost    <= pwdata[COST_WIDTH-1:0];
        aem_pkg::REG_BAND_HALFWIDTH:  band_halfwidth  <= pwdata[COST_WIDTH-1:0];
        aem_pkg::REG_TOLERANCE_LIMIT: tolerance_limit <= pwdata[COUNT_WIDTH-1:0];
        aem_pkg::REG_TARGET_COUNT:    target_count    <= pwdata[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      aem_pkg::REG_AVERAGE_COST:    prdata = PDATA_W'(unsigned'(average_cost));
      aem_pkg::REG_BAND_HALFWIDTH:  prdata = PDATA_W'(band_halfwidth);
      aem_pkg::REG_TOLERANCE_LIMIT: prdata = PDATA_W'(tolerance_limit);
      aem_pkg::REG_TARGET_COUNT:    prdata = PDATA_W'(target_count);
      default:                      prdata = '0;
    endcase
  end

endmodule

// ===== src/aem_core.sv =====
// cost statistics, band counters and per-step result logic
module aem_core #(
  parameter int COST_WIDTH  = 31,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic signed [COST_WIDTH-1:0]  step_cost,
  input  logic signed [COST_WIDTH-1:0]  current_cost,
  input  logic signed [COST_WIDTH-1:0]  average_cost,
  input  logic [COST_WIDTH-1:0]         band_halfwidth,
  input  logic [COUNT_WIDTH-1:0]        tolerance_limit,
  input  logic [COUNT_WIDTH-1:0]        target_count,
  output aem_pkg::aem_result_t          result
);

  localparam logic signed [COST_WIDTH-1:0] COST_MOST_NEG = {1'b1, {(COST_WIDTH-1){1'b0}}};
  localparam logic signed [COST_WIDTH-1:0] COST_MOST_POS = {1'b0, {(COST_WIDTH-1){1'b1}}};

  logic signed [COST_WIDTH-1:0] highest_cost, highest_cost_next;
  logic signed [COST_WIDTH-1:0] lowest_cost, lowest_cost_next;
  logic [COST_WIDTH:0]          largest_change, largest_change_next;
  logic [COUNT_WIDTH-1:0]       in_band_count, in_band_count_next;
  logic [COUNT_WIDTH-1:0]       out_band_count, out_band_count_next;

  logic signed [COST_WIDTH:0] step_x, cur_x, avg_x;
  logic signed [COST_WIDTH:0] diff_change, diff_band, range;
  logic [COST_WIDTH:0]        change, band_dist;
  logic                       in_band;
  logic [COUNT_WIDTH-1:0]     in_inc, out_inc;
  logic                       clear;

  always_comb begin
    step_x = {step_cost[COST_WIDTH-1], step_cost};
    cur_x  = {current_cost[COST_WIDTH-1], current_cost};
    avg_x  = {average_cost[COST_WIDTH-1], average_cost};

    highest_cost_next = (step_cost > highest_cost) ? step_cost : highest_cost;
    lowest_cost_next  = (step_cost < lowest_cost) ? step_cost : lowest_cost;

    diff_change = cur_x - step_x;
    change      = diff_change[COST_WIDTH] ? unsigned'(-diff_change) : unsigned'(diff_change);
    largest_change_next = (change > largest_change) ? change : largest_change;

    diff_band = avg_x - cur_x;
    band_dist = diff_band[COST_WIDTH] ? unsigned'(-diff_band) : unsigned'(diff_band);
    in_band   = band_dist <= {1'b0, band_halfwidth};

    // saturating increments
    in_inc  = (in_band_count == '1) ? in_band_count : in_band_count + 1'b1;
    out_inc = (out_band_count == '1) ? out_band_count : out_band_count + 1'b1;

    in_band_count_next  = in_band ? in_inc : in_band_count;
    out_band_count_next = in_band ? out_band_count : out_inc;

    clear = out_band_count_next > tolerance_limit;
    result.counts_cleared      = clear;
    result.equilibrium_reached = !clear && (in_band_count_next > target_count);
    if (clear) begin
      in_band_count_next  = '0;
      out_band_count_next = '0;
    end

    // negative range (no step yet) has the top bit set, change never does
    range = {highest_cost_next[COST_WIDTH-1], highest_cost_next}
          - {lowest_cost_next[COST_WIDTH-1], lowest_cost_next};
    result.frozen = unsigned'(range) == largest_change_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      highest_cost   <= COST_MOST_NEG;
      lowest_cost    <= COST_MOST_POS;
      largest_change <= '0;
      in_band_count  <= '0;
      out_band_count <= '0;
    end else if (advance) begin
      highest_cost   <= highest_cost_next;
      lowest_cost    <= lowest_cost_next;
      largest_change <= largest_change_next;
      in_band_count  <= in_band_count_next;
      out_band_count <= out_band_count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_excl: assert property (@(posedge clk) disable iff (rst)
    advance |-> !(result.counts_cleared && result.equilibrium_reached))
    else $error("clear and equilibrium flagged together");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    advance && result.counts_cleared |=> in_band_count == '0 && out_band_count == '0)
    else $error("counts not zero after clear");

  a_low_le_high: assert property (@(posedge clk) disable iff (rst)
    advance |=> lowest_cost <= highest_cost)
    else $error("lowest cost above highest cost after a step");
`endif

endmodule

// ===== sim/aem_flag_checker.sv =====
// flag predictor and result comparison for the annealing equilibrium monitor
module aem_flag_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,   // step_cost, current_cost, zero pad
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // equilibrium_reached, counts_cleared, frozen, zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          steps,
  output int          equil_seen,
  output int          cleared_seen,
  output int          frozen_seen
);

  localparam longint      COST_MOST_POS = (longint'(1) <<< 30) - 1;
  localparam longint      COST_MOST_NEG = -COST_MOST_POS - 1;
  localparam int unsigned COUNT_MAX     = 65535;

  // mirrored registers
  longint      avg_cost;
  longint      band;
  int unsigned tol;
  int unsigned tgt;

  // mirrored statistics
  longint      hi_cost;
  longint      lo_cost;
  longint      max_change;
  int unsigned in_cnt;
  int unsigned out_cnt;

  aem_pkg::aem_result_t pending_flags[$];
  int          err_cnt = 0;
  int          step_cnt = 0;
  int          eq_cnt = 0;
  int          clr_cnt = 0;
  int          frz_cnt = 0;

  function automatic longint cost_dist(longint a, longint b);
    longint d;
    d = a - b;
    return (d < 0) ? -d : d;
  endfunction

  function automatic int unsigned sat_inc(int unsigned c);
    return (c >= COUNT_MAX) ? COUNT_MAX : c + 1;
  endfunction

  function aem_pkg::aem_result_t next_flags(logic [30:0] step_raw, logic [30:0] cur_raw);
    longint      step_v;
    longint      cur_v;
    longint      change;
    aem_pkg::aem_result_t r;
    r      = '0;
    step_v = longint'($signed(step_raw));
    cur_v  = longint'($signed(cur_raw));
    if (step_v > hi_cost) hi_cost = step_v;
    if (step_v < lo_cost) lo_cost = step_v;
    change = cost_dist(cur_v, step_v);
    if (change > max_change) max_change = change;
    if (cost_dist(avg_cost, cur_v) <= band) in_cnt = sat_inc(in_cnt);
    else out_cnt = sat_inc(out_cnt);
    if (out_cnt > tol) begin
      out_cnt = 0;
      in_cnt  = 0;
      r.counts_cleared = 1'b1;
    end else if (in_cnt > tgt) begin
      r.equilibrium_reached = 1'b1;
    end
    r.frozen = ((hi_cost - lo_cost) == max_change);
    return r;
  endfunction

  task check_flag(input string name, input logic want, input logic got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    aem_pkg::aem_result_t got;
    aem_pkg::aem_result_t want;
    if (rst) begin
      avg_cost   = 0;
      band       = 0;
      tol        = 0;
      tgt        = 0;
      hi_cost    = COST_MOST_NEG;
      lo_cost    = COST_MOST_POS;
      max_change = 0;
      in_cnt     = 0;
      out_cnt    = 0;
      pending_flags.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          aem_pkg::REG_AVERAGE_COST:    avg_cost = longint'($signed(pwdata[30:0]));
          aem_pkg::REG_BAND_HALFWIDTH:  band     = longint'(pwdata[30:0]);
          aem_pkg::REG_TOLERANCE_LIMIT: tol      = 32'(pwdata[15:0]);
          aem_pkg::REG_TARGET_COUNT:    tgt      = 32'(pwdata[15:0]);
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = aem_pkg::aem_result_t'(m_tdata[2:0]);
        if (pending_flags.size() == 0) begin
          err_cnt++;
          $display("%0t: result with no step waiting, expected none, actual eq=%0b clr=%0b frz=%0b",
                   $time, got.equilibrium_reached, got.counts_cleared, got.frozen);
        end else begin
          want = pending_flags.pop_front();
          check_flag("equilibrium_reached", want.equilibrium_reached, got.equilibrium_reached);
          check_flag("counts_cleared", want.counts_cleared, got.counts_cleared);
          check_flag("frozen", want.frozen, got.frozen);
        end
        eq_cnt  += got.equilibrium_reached;
        clr_cnt += got.counts_cleared;
        frz_cnt += got.frozen;
      end
      if (s_tvalid && s_tready) begin
        pending_flags.push_back(next_flags(s_tdata[30:0], s_tdata[61:31]));
        step_cnt++;
      end
    end
    errors       <= err_cnt;
    pending      <= pending_flags.size();
    steps        <= step_cnt;
    equil_seen   <= eq_cnt;
    cleared_seen <= clr_cnt;
    frozen_seen  <= frz_cnt;
  end

endmodule

// ===== sim/annealing_equilibrium_monitor_tb.sv =====
// stimulus and verdict for the annealing equilibrium monitor
module annealing_equilibrium_monitor_tb;

  localparam longint COST_MOST_POS = (longint'(1) <<< 30) - 1;
  localparam longint COST_MOST_NEG = -COST_MOST_POS - 1;
  localparam int     QUIET_LIMIT   = 4000;    // cycles with no transfer before giving up
  localparam int     PHASE_STEPS   = 120;
  localparam int     SOAK_STEPS    = 60;      // long enough for the in count to pass the target

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;     // step_cost, current_cost, zero pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;          // equilibrium_reached, counts_cleared, frozen, zero pad
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int pending_results;
  int steps;
  int equil_seen;
  int cleared_seen;
  int frozen_seen;

  // idling knobs, percent of cycles
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;

  // stimulus-side copy of the band, used only to shape current costs
  longint cfg_avg  = 0;
  longint cfg_band = 0;
  int     settings_run = 0;
  int     quiet_cycles = 0;

  annealing_equilibrium_monitor #(
    .COST_WIDTH  (31),
    .COUNT_WIDTH (16)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  aem_flag_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .errors       (errors),
    .pending      (pending_results),
    .steps        (steps),
    .equil_seen   (equil_seen),
    .cleared_seen (cleared_seen),
    .frozen_seen  (frozen_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // watchdog: any transfer on any port restarts the count
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_results);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one apb write: setup cycle, then access cycle until pready; select stays up
  // so that writes can follow back to back
  task cfg_write(input aem_pkg::reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // stop sending and wait for every outstanding result
  task drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // one step transfer; valid stays high afterwards unless the next one idles first
  task send_step(input longint step_cost, input longint cur_cost);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, cur_cost[30:0], step_cost[30:0]};
    do @(posedge clk); while (!s_tready);
  endtask

  // current cost mostly at the centre, on the band edges or inside the band, step cost near it or anywhere
  task send_random_step();
    int          mode;
    longint      b;
    longint      cur_cost;
    longint      step_cost;
    logic [30:0] raw;
    b    = (cfg_band > (longint'(1) <<< 30)) ? (longint'(1) <<< 30) : cfg_band;
    mode = $urandom_range(9);
    case (mode)
      0: cur_cost = cfg_avg;
      1: cur_cost = cfg_avg + cfg_band;
      2: cur_cost = cfg_avg - cfg_band;
      3: cur_cost = cfg_avg + cfg_band + 1;
      4: cur_cost = cfg_avg - cfg_band - 1;
      5, 6: cur_cost = cfg_avg + longint'($urandom_range(32'(2 * b))) - b;
      default: begin
        raw = 31'($urandom);
        cur_cost = longint'($signed(raw));
      end
    endcase
    case ($urandom_range(3))
      0: step_cost = cur_cost;
      1: step_cost = cur_cost + longint'($urandom_range(510)) - 255;
      default: begin
        raw = 31'($urandom);
        step_cost = longint'($signed(raw));
      end
    endcase
    send_step(step_cost, cur_cost);
  endtask

  // write all four registers with junk above each register's width
  task apply_settings(input longint avg, input longint band, input int tol, input int tgt);
    logic [31:0] junk;
    drain();
    junk = $urandom;
    cfg_write(aem_pkg::REG_AVERAGE_COST, {junk[31], avg[30:0]});
    cfg_write(aem_pkg::REG_BAND_HALFWIDTH, {junk[30], band[30:0]});
    cfg_write(aem_pkg::REG_TOLERANCE_LIMIT, {junk[15:0], 16'(tol)});
    cfg_write(aem_pkg::REG_TARGET_COUNT, {junk[31:16], 16'(tgt)});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_avg  = avg;
    cfg_band = band;
    settings_run++;
  endtask

  task run_phase(input longint avg, input longint band, input int tol, input int tgt,
                 input int tx_idle, input int rx_stall, input bit hold_off);
    apply_settings(avg, band, tol, tgt);
    tx_idle_pct  = tx_idle;
    rx_stall_pct = rx_stall;
    for (int i = 0; i < PHASE_STEPS; i++) begin
      // sender holds off mid-phase until the block has emptied
      if (hold_off && i == PHASE_STEPS / 2) drain();
      send_random_step();
    end
  endtask

  function automatic longint rand_cost();
    logic [30:0] raw;
    raw = 31'($urandom);
    return longint'($signed(raw));
  endfunction

  // directed steps against a centre of 0 and a half-width of 100
  longint dir_step [15] = '{5, 10, -10, 0, 0, 0, 0, 0, 0, 0,
                            COST_MOST_POS, COST_MOST_NEG, COST_MOST_NEG, COST_MOST_POS, 0};
  longint dir_cur  [15] = '{5, 5, 10, 100, -100, 101, -101, 1000, -1000, 0,
                            COST_MOST_POS, COST_MOST_NEG, COST_MOST_POS, COST_MOST_NEG, 0};

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: frozen on a flat start, band edges, equilibrium held over several
    // steps, clear winning over equilibrium, then the cost extremes
    apply_settings(0, 100, 3, 2);
    for (int i = 0; i < 15; i++) send_step(dir_step[i], dir_cur[i]);

    // random phases over a spread of settings and idling patterns
    run_phase(COST_MOST_NEG, COST_MOST_POS, 0, 0, 0, 0, 1'b0);
    run_phase(COST_MOST_POS, 0, 0, 65535, 86, 0, 1'b0);
    run_phase(rand_cost(), $urandom_range(4000), $urandom_range(20), $urandom_range(20),
              0, 86, 1'b1);
    run_phase(0, 5000, 5, 8, 33, 33, 1'b0);
    run_phase(rand_cost(), longint'($urandom_range(32'h7fff_ffff)), $urandom_range(65535),
              $urandom_range(65535), 0, 0, 1'b0);
    run_phase(-12345, 65536, 65535, 2, 86, 0, 1'b0);
    run_phase(rand_cost(), $urandom_range(100000), $urandom_range(12), $urandom_range(12),
              0, 86, 1'b0);
    run_phase(rand_cost(), $urandom_range(2000), $urandom_range(6), $urandom_range(30),
              33, 33, 1'b0);

    // soak: alternate in and out of band under a tolerance that is never passed,
    // equilibrium must hold on every step once the in count passes the target
    apply_settings(0, 1000, 65535, 20);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    for (int i = 0; i < SOAK_STEPS; i++) send_step(0, (i % 2) ? 5000 : 0);

    // low limits afterwards: the counts left high clear on the very next step
    run_phase(0, 1000, 10, 10, 33, 33, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    $display("%0d steps checked over %0d register settings", steps, settings_run);
    $display("flags seen: %0d equilibrium, %0d cleared, %0d frozen",
             equil_seen, cleared_seen, frozen_seen);
    if (errors == 0 && pending_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/aem_pkg.sv
src/aem_regs.sv
src/aem_core.sv
src/annealing_equilibrium_monitor.sv
sim/aem_flag_checker.sv
sim/annealing_equilibrium_monitor_tb.sv
